### sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared constants and codes for the point to segment distance unit
// ----------------------------------------------------------------------------
package psd_pkg;

  // width of the distance result, saturating
  localparam int DIST_BITS = 26;

  // how the projection fraction is chosen
  typedef enum logic [1:0] {
    FRAC_ZERO = 2'd0,
    FRAC_ONE  = 2'd1,
    FRAC_DIV  = 2'd2
  } frac_sel_t;

endpackage

### sv/psd_req_if.sv
// ----------------------------------------------------------------------------
// psd_req_if
// request channel: query point and segment end points, valid/ready
// ----------------------------------------------------------------------------
interface psd_req_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (
    output valid, point_x, point_y, point_z, start_x, start_y, start_z,
    output end_x, end_y, end_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
    input  end_x, end_y, end_z,
    output ready
  );
endinterface

### sv/psd_rsp_if.sv
// ----------------------------------------------------------------------------
// psd_rsp_if
// response channel: distance, clamped fraction and degenerate flag
// ----------------------------------------------------------------------------
interface psd_rsp_if #(
  parameter int FRACTION_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [psd_pkg::DIST_BITS-1:0]  distance;
  logic [FRACTION_BITS:0]         fraction;
  logic                           degenerate;

  modport source (
    output valid, distance, fraction, degenerate,
    input  ready
  );

  modport sink (
    input  valid, distance, fraction, degenerate,
    output ready
  );
endinterface

### sv/psd_frac_div.sv
// ----------------------------------------------------------------------------
// psd_frac_div
// pipelined restoring divider, one quotient bit per stage, num < den
// ----------------------------------------------------------------------------
module psd_frac_div #(
  parameter int NUM_W  = 52,
  parameter int STEPS  = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [NUM_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [STEPS-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  logic [NUM_W-1:0]  rem_q  [STEPS-1];
  logic [NUM_W-1:0]  den_q  [STEPS-1];
  logic [STEPS-1:0]  quot_q [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic              vld_q  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [NUM_W-1:0]  rem_in;
    logic [NUM_W-1:0]  den_in;
    logic [STEPS-1:0]  quot_in;
    logic [SIDE_W-1:0] side_k;
    logic              vld_in;
    logic [NUM_W:0]    trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign quot_in = '0;
      assign side_k  = side_in;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_k  = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // shifted remainder against the divisor
    assign trial = {rem_in, 1'b0};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quot_q[k] <= {quot_in[STEPS-2:0], take};
        side_q[k] <= side_k;
      end
    end

    if (k < STEPS-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? NUM_W'(trial - {1'b0, den_in}) : trial[NUM_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign quot      = quot_q[STEPS-1];
  assign side_out  = side_q[STEPS-1];

endmodule

### sv/psd_isqrt.sv
// ----------------------------------------------------------------------------
// psd_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module psd_isqrt #(
  parameter int ROOT_W = 26,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int REM_W = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;

  logic [REM_W-1:0]  rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_in;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_k;
    logic              vld_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = radicand;
      assign root_in = '0;
      assign side_k  = side_in;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign side_k  = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // bring down the next bit pair, try root*4+1
    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        side_q[k] <= side_k;
      end
    end

    if (k < ROOT_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= take ? REM_W'(cur - trial) : cur[REM_W-1:0];
          rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = vld_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign side_out  = side_q[ROOT_W-1];

endmodule

### sv/point_segment_distance_3d_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_3d_unit
// distance from a 3d point to a segment, with clamped projection fraction
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   -------  ---  ------------  ----------------------------------------------
//   req      in   valid/ready   point_x/y/z, start_x/y/z, end_x/y/z (signed)
//   rsp      out  valid/ready   distance, fraction, degenerate
//
// one request per cycle while the response side keeps up; most of the depth
// comes from the one-bit-per-stage divider for the fraction and the 26 stages
// of the square root
// reset clears all stage valid bits; payload registers are not reset
// a stalled response freezes the whole pipeline with one enable; an empty
// output slot never stalls it, so req.ready is high whenever it is free
// ----------------------------------------------------------------------------
module point_segment_distance_3d_unit #(
  parameter int COORD_BITS    = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  psd_req_if.sink    req,
  psd_rsp_if.source  rsp
);
  import psd_pkg::*;

  // difference width, product and sum widths
  localparam int RW   = COORD_BITS + 1;
  localparam int PW   = 2 * RW;
  localparam int DW   = 2 * RW + 2;
  localparam int FW   = FRACTION_BITS + 1;
  // error term per axis, scaled by 2^FRACTION_BITS
  localparam int EW   = RW + FRACTION_BITS + 2;
  localparam int KL   = (EW + 1) / 2;
  localparam int KH   = EW - KL;
  localparam int SQW  = 2 * EW;
  localparam int TW   = 2 * DIST_BITS;
  localparam int SUMW = (SQW + 2 > 2 * FRACTION_BITS + TW) ? SQW + 2
                                                           : 2 * FRACTION_BITS + TW + 1;
  localparam int DSIDE_W = 6 * RW + 3;
  localparam int QSIDE_W = FW + 2;

  localparam logic [FW-1:0] FracOne = FW'(1) << FRACTION_BITS;

  // fraction and flag travelling with the distance datapath
  typedef struct packed {
    logic [FW-1:0] frac;
    logic          degen;
  } tail_t;

  logic en;

  // pipeline freezes only when a finished response is not taken
  logic out_valid;
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // ---------------------------------------------------------------- stage 1
  // relative position and direction, exact
  logic                 s1_valid;
  logic signed [RW-1:0] s1_rel [3];
  logic signed [RW-1:0] s1_dir [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rel[0] <= RW'(req.point_x) - RW'(req.start_x);
      s1_rel[1] <= RW'(req.point_y) - RW'(req.start_y);
      s1_rel[2] <= RW'(req.point_z) - RW'(req.start_z);
      s1_dir[0] <= RW'(req.end_x) - RW'(req.start_x);
      s1_dir[1] <= RW'(req.end_y) - RW'(req.start_y);
      s1_dir[2] <= RW'(req.end_z) - RW'(req.start_z);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // per-axis products for the dot product and squared length
  logic                 s2_valid;
  logic signed [PW-1:0] s2_prd [3];
  logic        [PW-1:0] s2_sq  [3];
  logic signed [RW-1:0] s2_rel [3];
  logic signed [RW-1:0] s2_dir [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_prd[i] <= s1_rel[i] * s1_dir[i];
        s2_sq[i]  <= PW'(s1_dir[i] * s1_dir[i]);
        s2_rel[i] <= s1_rel[i];
        s2_dir[i] <= s1_dir[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                 s3_valid;
  logic signed [DW-1:0] s3_dot;
  logic        [DW-1:0] s3_den;
  logic signed [RW-1:0] s3_rel [3];
  logic signed [RW-1:0] s3_dir [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_dot <= DW'(s2_prd[0]) + DW'(s2_prd[1]) + DW'(s2_prd[2]);
      s3_den <= DW'(s2_sq[0]) + DW'(s2_sq[1]) + DW'(s2_sq[2]);
      for (int i = 0; i < 3; i++) begin
        s3_rel[i] <= s2_rel[i];
        s3_dir[i] <= s2_dir[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 4
  // classify: zero-length segment, before start, past end, or divide
  logic                 s4_valid;
  logic                 s4_degen;
  frac_sel_t            s4_sel;
  logic        [DW-1:0] s4_num;
  logic        [DW-1:0] s4_den;
  logic signed [RW-1:0] s4_rel [3];
  logic signed [RW-1:0] s4_dir [3];

  logic      degen_next;
  frac_sel_t sel_next;

  always_comb begin
    degen_next = (s3_den == '0);
    priority if (degen_next) begin
      sel_next = FRAC_ZERO;
    end else if (s3_dot[DW-1] || s3_dot == '0) begin
      sel_next = FRAC_ZERO;
    end else if ($unsigned(s3_dot) >= s3_den) begin
      sel_next = FRAC_ONE;
    end else begin
      sel_next = FRAC_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_degen <= degen_next;
      s4_sel   <= sel_next;
      s4_num   <= (sel_next == FRAC_DIV) ? $unsigned(s3_dot) : '0;
      s4_den   <= s3_den;
      for (int i = 0; i < 3; i++) begin
        s4_rel[i] <= s3_rel[i];
        s4_dir[i] <= s3_dir[i];
      end
    end
  end

  // ---------------------------------------------------------------- divider
  logic                     div_valid;
  logic [FRACTION_BITS-1:0] div_quot;
  logic [DSIDE_W-1:0]       div_side_in;
  logic [DSIDE_W-1:0]       div_side_out;
  logic                     d_degen;
  logic [1:0]               d_sel;
  logic signed [RW-1:0]     d_rel [3];
  logic signed [RW-1:0]     d_dir [3];

  assign div_side_in = {s4_degen, s4_sel, s4_rel[0], s4_rel[1], s4_rel[2],
                        s4_dir[0], s4_dir[1], s4_dir[2]};

  psd_frac_div #(
    .NUM_W  (DW),
    .STEPS  (FRACTION_BITS),
    .SIDE_W (DSIDE_W)
  ) u_frac_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .num       (s4_num),
    .den       (s4_den),
    .side_in   (div_side_in),
    .out_valid (div_valid),
    .quot      (div_quot),
    .side_out  (div_side_out)
  );

  assign {d_degen, d_sel, d_rel[0], d_rel[1], d_rel[2],
          d_dir[0], d_dir[1], d_dir[2]} = div_side_out;

  // ---------------------------------------------------------------- stage 5
  // final clamped fraction
  logic                 s5_valid;
  tail_t                s5_tail;
  logic signed [RW-1:0] s5_rel [3];
  logic signed [RW-1:0] s5_dir [3];
  logic [FW-1:0]        frac_next;

  always_comb begin
    unique case (frac_sel_t'(d_sel))
      FRAC_ZERO: frac_next = '0;
      FRAC_ONE:  frac_next = FracOne;
      FRAC_DIV:  frac_next = {1'b0, div_quot};
      default:   frac_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tail.frac  <= frac_next;
      s5_tail.degen <= d_degen;
      for (int i = 0; i < 3; i++) begin
        s5_rel[i] <= d_rel[i];
        s5_dir[i] <= d_dir[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 6
  // fraction times direction
  logic                 s6_valid;
  tail_t                s6_tail;
  logic signed [EW-1:0] s6_fd  [3];
  logic signed [RW-1:0] s6_rel [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tail <= s5_tail;
      for (int i = 0; i < 3; i++) begin
        s6_fd[i]  <= $signed({1'b0, s5_tail.frac}) * s5_dir[i];
        s6_rel[i] <= s5_rel[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 7
  // scaled error vector from the nearest point
  logic                 s7_valid;
  tail_t                s7_tail;
  logic signed [EW-1:0] s7_e [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_tail <= s6_tail;
      for (int i = 0; i < 3; i++) begin
        s7_e[i] <= (EW'(s6_rel[i]) <<< FRACTION_BITS) - s6_fd[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 8
  // magnitudes
  logic          s8_valid;
  tail_t         s8_tail;
  logic [EW-1:0] s8_m [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_tail <= s7_tail;
      for (int i = 0; i < 3; i++) begin
        s8_m[i] <= s7_e[i][EW-1] ? (~s7_e[i] + EW'(1)) : s7_e[i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 9
  // squares split into half-width partial products
  logic               s9_valid;
  tail_t              s9_tail;
  logic [2*KH-1:0]    s9_hh [3];
  logic [KH+KL-1:0]   s9_hl [3];
  logic [2*KL-1:0]    s9_ll [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= s8_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_tail <= s8_tail;
      for (int i = 0; i < 3; i++) begin
        s9_hh[i] <= s8_m[i][EW-1:KL] * s8_m[i][EW-1:KL];
        s9_hl[i] <= s8_m[i][EW-1:KL] * s8_m[i][KL-1:0];
        s9_ll[i] <= s8_m[i][KL-1:0] * s8_m[i][KL-1:0];
      end
    end
  end

  // --------------------------------------------------------------- stage 10
  logic           s10_valid;
  tail_t          s10_tail;
  logic [SQW-1:0] s10_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_tail <= s9_tail;
      for (int i = 0; i < 3; i++) begin
        s10_sq[i] <= (SQW'(s9_hh[i]) << (2 * KL)) + (SQW'(s9_hl[i]) << (KL + 1))
                   + SQW'(s9_ll[i]);
      end
    end
  end

  // --------------------------------------------------------------- stage 11
  logic            s11_valid;
  tail_t           s11_tail;
  logic [SUMW-1:0] s11_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else if (en) begin
      s11_valid <= s10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_tail <= s10_tail;
      s11_sum  <= SUMW'(s10_sq[0]) + SUMW'(s10_sq[1]) + SUMW'(s10_sq[2]);
    end
  end

  // --------------------------------------------------------------- stage 12
  // drop the squared scale before the root; flag sums past the output range
  logic          s12_valid;
  tail_t         s12_tail;
  logic [TW-1:0] s12_rad;
  logic          s12_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else if (en) begin
      s12_valid <= s11_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s12_tail <= s11_tail;
      s12_rad  <= s11_sum[2*FRACTION_BITS+TW-1:2*FRACTION_BITS];
      s12_sat  <= |s11_sum[SUMW-1:2*FRACTION_BITS+TW];
    end
  end

  // ------------------------------------------------------------ square root
  logic                 sq_valid;
  logic [DIST_BITS-1:0] sq_root;
  logic [QSIDE_W-1:0]   sq_side;
  tail_t                q_tail;
  logic                 q_sat;

  psd_isqrt #(
    .ROOT_W (DIST_BITS),
    .SIDE_W (QSIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s12_valid),
    .radicand  (s12_rad),
    .side_in   ({s12_tail, s12_sat}),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  assign {q_tail, q_sat} = sq_side;

  // -------------------------------------------------------- output register
  logic [DIST_BITS-1:0] out_distance;
  logic [FW-1:0]        out_fraction;
  logic                 out_degenerate;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_distance   <= q_sat ? '1 : sq_root;
      out_fraction   <= q_tail.frac;
      out_degenerate <= q_tail.degen;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.distance   = out_distance;
  assign rsp.fraction   = out_fraction;
  assign rsp.degenerate = out_degenerate;

endmodule

### sv/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// port-level checks on the distance unit, bound to the top level
// ----------------------------------------------------------------------------
module psd_checker #(
  parameter int FRACTION_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [psd_pkg::DIST_BITS-1:0] distance,
  input logic [FRACTION_BITS:0]        fraction,
  input logic                          degenerate
);

  localparam logic [FRACTION_BITS:0] FracOne = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  // a waiting response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(distance) && $stable(fraction)
                                && $stable(degenerate))
    else $error("response changed while stalled");

  // no response straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // an empty output never blocks requests
  a_ready_free: assert property (@(posedge clk) !rsp_valid |-> req_ready)
    else $error("request refused with free output");

  // zero-length segment forces the fraction to zero
  a_degen_frac: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && degenerate |-> fraction == '0)
    else $error("degenerate segment with nonzero fraction");

  // fraction is clamped to one
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fraction <= FracOne)
    else $error("fraction above one");

endmodule

bind point_segment_distance_3d_unit psd_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_psd_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .distance   (rsp.distance),
  .fraction   (rsp.fraction),
  .degenerate (rsp.degenerate)
);

### tb/psd_distance_checker.sv
// ----------------------------------------------------------------------------
// psd_distance_checker
// watches both channels, predicts each response and compares it field by field
// ----------------------------------------------------------------------------
module psd_distance_checker #(
  parameter int COORD_BITS    = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  psd_req_if   req,
  psd_rsp_if   rsp,
  output int   mismatch_count,
  output int   results_pending
);
  import psd_pkg::*;

  typedef struct packed {
    logic [DIST_BITS-1:0]   distance;
    logic [FRACTION_BITS:0] fraction;
    logic                   degenerate;
  } segment_result_t;

  segment_result_t awaited_results[$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
  end

  // exact integer projection, truncated fraction, then floor of the true distance
  function automatic segment_result_t nearest_point_distance(
    input logic [2:0][COORD_BITS-1:0] pt,
    input logic [2:0][COORD_BITS-1:0] seg_a,
    input logic [2:0][COORD_BITS-1:0] seg_b
  );
    longint          rel [3];
    longint          dir [3];
    longint          dot;
    longint          len_sq;
    longint          unit;
    longint          frac_l;
    longint          err;
    logic [127:0]    quot;
    logic [127:0]    mag;
    logic [127:0]    sum_sq;
    logic [127:0]    root;
    logic [127:0]    cand;
    segment_result_t res;

    unit   = longint'(1) << FRACTION_BITS;
    dot    = 0;
    len_sq = 0;
    sum_sq = '0;
    res    = '0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = longint'(signed'(pt[i])) - longint'(signed'(seg_a[i]));
      dir[i] = longint'(signed'(seg_b[i])) - longint'(signed'(seg_a[i]));
      dot    += rel[i] * dir[i];
      len_sq += dir[i] * dir[i];
    end

    res.degenerate = (len_sq == 0);
    if (len_sq == 0 || dot <= 0) begin
      res.fraction = '0;
    end else if (dot >= len_sq) begin
      res.fraction = unit[FRACTION_BITS:0];
    end else begin
      quot = ({64'd0, dot} << FRACTION_BITS) / {64'd0, len_sq};
      res.fraction = quot[FRACTION_BITS:0];
    end

    frac_l = longint'(res.fraction);
    for (int i = 0; i < 3; i++) begin
      err    = rel[i] * unit - frac_l * dir[i];
      mag    = {64'd0, (err < 0) ? -err : err};
      sum_sq += mag * mag;
    end

    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sum_sq) root = cand;
    end
    root = root >> FRACTION_BITS;
    if (root > {{(128 - DIST_BITS){1'b0}}, {DIST_BITS{1'b1}}}) res.distance = '1;
    else res.distance = root[DIST_BITS-1:0];
    return res;
  endfunction

  // one line per mismatch, and counted
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    segment_result_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        awaited_results.push_back(nearest_point_distance(
          {req.point_z, req.point_y, req.point_x},
          {req.start_z, req.start_y, req.start_x},
          {req.end_z, req.end_y, req.end_x}));
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("response with no request waiting, distance %0d",
                                    rsp.distance));
        end else begin
          want = awaited_results.pop_front();
          if (rsp.distance !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d",
                                      rsp.distance, want.distance));
          if (rsp.fraction !== want.fraction)
            report_mismatch($sformatf("fraction %0d, expected %0d",
                                      rsp.fraction, want.fraction));
          if (rsp.degenerate !== want.degenerate)
            report_mismatch($sformatf("degenerate %0b, expected %0b",
                                      rsp.degenerate, want.degenerate));
        end
      end
    end
    results_pending <= awaited_results.size();
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the point to segment distance unit
// ----------------------------------------------------------------------------
//
// a directed set of corner requests goes first: zero-length segments, points
// projecting before the start, exactly on the start, exactly on the end and
// past the end, the coordinate extremes and alternating bit patterns
// after that four random phases run, each with its own idling pattern:
// none at all, sender idle most of the time, receiver stalling most of the
// time, and a light mix of both
// the first phase also holds the response side off for a long stretch so
// the pipeline fills up and pushes back on the request side
// between phases the sender waits until every predicted response is back
// all prediction and comparison lives in the checker beside the unit
// ----------------------------------------------------------------------------
module tb;
  import psd_pkg::*;

  localparam int COORD_BITS    = 24;
  localparam int FRACTION_BITS = 16;

  // idle time after the last phase before the verdict is given
  localparam int DRAIN_CYCLES  = 120;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 357;
  localparam int CYCLE_LIMIT   = 200000;

  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
  // 0xaaaaaa and 0x555555 seen as signed 24-bit values
  localparam longint PAT_A     = -5592406;
  localparam longint PAT_B     = 5592405;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t px, py, pz;
    coord_t ax, ay, az;
    coord_t bx, by, bz;
  } segment_query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
  int holds_asked   = 0;   // bumped by the stimulus to ask for a long hold-off
  int cycle_count   = 0;
  int chk_failures;
  int chk_pending;

  psd_req_if #(.COORD_BITS(COORD_BITS))       req_ch ();
  psd_rsp_if #(.FRACTION_BITS(FRACTION_BITS)) rsp_ch ();

  point_segment_distance_3d_unit #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  psd_distance_checker #(
    .COORD_BITS   (COORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) chk (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (chk_failures),
    .results_pending(chk_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a response never turns up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // response side: random stalls, plus a long hold-off whenever one is asked
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left     = 0;
    holds_served  = 0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // values are truncated to the coordinate width on the way in
  function automatic segment_query_t query(
    input longint px, py, pz, ax, ay, az, bx, by, bz
  );
    segment_query_t q;
    q.px = coord_t'(px); q.py = coord_t'(py); q.pz = coord_t'(pz);
    q.ax = coord_t'(ax); q.ay = coord_t'(ay); q.az = coord_t'(az);
    q.bx = coord_t'(bx); q.by = coord_t'(by); q.bz = coord_t'(bz);
    return q;
  endfunction

  function automatic longint span(input longint half);
    return longint'($urandom_range(0, 32'(2 * half))) - half;
  endfunction

  // a mix of query shapes, most often a point near the segment
  function automatic segment_query_t random_query();
    segment_query_t q;
    longint a [3];
    longint b [3];
    longint p [3];
    longint t;
    longint noise;
    int     kind;
    kind = $urandom_range(99);
    if (kind < 30) begin
      // anything the fields allow
      q.px = coord_t'($urandom()); q.py = coord_t'($urandom()); q.pz = coord_t'($urandom());
      q.ax = coord_t'($urandom()); q.ay = coord_t'($urandom()); q.az = coord_t'($urandom());
      q.bx = coord_t'($urandom()); q.by = coord_t'($urandom()); q.bz = coord_t'($urandom());
    end else if (kind < 50) begin
      // everything close to the origin, so the fraction has fine detail
      q = query(span(2000), span(2000), span(2000), span(2000), span(2000), span(2000),
                span(2000), span(2000), span(2000));
    end else if (kind < 60) begin
      // zero-length segment
      q.px = coord_t'($urandom()); q.py = coord_t'($urandom()); q.pz = coord_t'($urandom());
      q.ax = coord_t'($urandom()); q.ay = coord_t'($urandom()); q.az = coord_t'($urandom());
      q.bx = q.ax; q.by = q.ay; q.bz = q.az;
    end else if (kind < 66) begin
      // very short segment with the point anywhere
      q.px = coord_t'($urandom()); q.py = coord_t'($urandom()); q.pz = coord_t'($urandom());
      q.ax = coord_t'(span(1 << 22)); q.ay = coord_t'(span(1 << 22));
      q.az = coord_t'(span(1 << 22));
      q.bx = q.ax + coord_t'(span(1)); q.by = q.ay + coord_t'(span(1));
      q.bz = q.az + coord_t'(span(1));
    end else begin
      // point near the segment, from a little before the start to past the end
      t     = longint'($urandom_range(0, 300)) - 22;
      noise = ($urandom_range(3) == 0) ? 0 : 64;
      for (int i = 0; i < 3; i++) begin
        a[i] = span(1 << 22);
        b[i] = span(1 << 22);
        p[i] = a[i] + ((b[i] - a[i]) * t) / 256 + span(noise);
      end
      q = query(p[0], p[1], p[2], a[0], a[1], a[2], b[0], b[1], b[2]);
    end
    return q;
  endfunction

  // offer one request, idling first at random, and return once it is taken
  task automatic send_query(input segment_query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.point_x <= q.px;
    req_ch.point_y <= q.py;
    req_ch.point_z <= q.pz;
    req_ch.start_x <= q.ax;
    req_ch.start_y <= q.ay;
    req_ch.start_z <= q.az;
    req_ch.end_x   <= q.bx;
    req_ch.end_y   <= q.by;
    req_ch.end_z   <= q.bz;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
  endtask

  initial begin : stimulus
    req_ch.valid   = 1'b0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.point_z = '0;
    req_ch.start_x = '0;
    req_ch.start_y = '0;
    req_ch.start_z = '0;
    req_ch.end_x   = '0;
    req_ch.end_y   = '0;
    req_ch.end_z   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero-length segments, including the largest possible distance
    send_query(query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MIN, COORD_MIN, COORD_MIN));
    send_query(query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MAX, COORD_MAX, COORD_MAX));
    send_query(query(123, -456, 789, 123, -456, 789, 123, -456, 789));
    // projection before the start, exactly at it, exactly at the end, past it
    send_query(query(-500, 300, 0, 0, 0, 0, 1000, 0, 0));
    send_query(query(0, 700, 0, 0, 0, 0, 1000, 0, 0));
    send_query(query(1000, -40, 9, 0, 0, 0, 1000, 0, 0));
    send_query(query(2500, 10, 10, 0, 0, 0, 1000, 0, 0));
    // fractions strictly inside
    send_query(query(1, 0, 0, 0, 0, 0, 3, 0, 0));
    send_query(query(500, 100, -100, 0, 0, 0, 1000, 0, 0));
    // longest segments, points on the ends, the middle and off to the side
    send_query(query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MAX, COORD_MAX));
    send_query(query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MAX, COORD_MAX));
    send_query(query(0, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN,
                     COORD_MAX, COORD_MAX, COORD_MAX));
    send_query(query(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                     COORD_MIN, COORD_MAX, COORD_MIN));
    send_query(query(COORD_MAX, COORD_MIN, 0, COORD_MAX, COORD_MAX, COORD_MAX,
                     COORD_MIN, COORD_MIN, COORD_MIN));
    send_query(query(0, 0, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, 0, 0));
    // unit-length segments with the point far away
    send_query(query(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 1, 0, 0));
    send_query(query(COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 0, 0, 0, 1));
    send_query(query(7, 7, 7, -3, 2, 5, -3, 2, 6));
    // alternating bit patterns on every field
    send_query(query(PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_A, PAT_B));
    send_query(query(PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_B, PAT_A));
    send_query(query(-1, -1, -1, 1, 1, 1, -1, -1, -1));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 75;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 75;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct     = 12;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off while requests keep coming, so the pipeline backs up
        if (phase == 0 && n == 80) holds_asked++;
        send_query(random_query());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk_failures == 0 && chk_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
sv/psd_pkg.sv
sv/psd_req_if.sv
sv/psd_rsp_if.sv
sv/psd_frac_div.sv
sv/psd_isqrt.sv
sv/point_segment_distance_3d_unit.sv
sv/psd_checker.sv
tb/psd_distance_checker.sv
tb/tb.sv
